FILE: src/apu_pkg.sv
// Shared constants, register codes and unit request and response types for the Adam update block.
package apu_pkg;

  localparam int MAX_TENSORS_DEF         = 4;
  localparam int ELEMENTS_PER_TENSOR_DEF = 1024;
  localparam int DECAY_PERIOD_DEF        = 10000;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_LEARNING_RATE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BETA_FIRST      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BETA_SECOND     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_EPSILON_VALUE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCHEDULE_ENABLE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_WARMUP_LENGTH   = 3'd5;

  localparam logic [23:0] LEARNING_RATE_RST = 24'd16777;
  localparam logic [15:0] BETA_FIRST_RST    = 16'd58982;
  localparam logic [15:0] BETA_SECOND_RST   = 16'd65470;
  localparam logic [31:0] EPSILON_RST       = 32'd43;
  localparam logic [31:0] POWER_ONE         = 32'hFFFF_FFFF;

  localparam int DIV_STEPS_W = 6;
  localparam int DIV_REM0_W  = 24;
  localparam int DIV_LOW_W   = 48;
  localparam int DIV_DEN_W   = 37;

  typedef struct packed {
    logic                   start;
    logic [DIV_STEPS_W-1:0] steps;
    logic [DIV_REM0_W-1:0]  rem0;
    logic [DIV_LOW_W-1:0]   low;
    logic [DIV_DEN_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_LOW_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

endpackage

FILE: src/apu_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
module apu_div (
  input  logic              clk,
  input  logic              rst_n,
  input  apu_pkg::div_req_t req,
  output apu_pkg::div_rsp_t rsp
);
  import apu_pkg::*;

  logic [DIV_DEN_W-1:0]   rem_r;
  logic [DIV_DEN_W-1:0]   div_r;
  logic [DIV_LOW_W-1:0]   low_r;
  logic [DIV_LOW_W-1:0]   quo_r;
  logic [DIV_STEPS_W-1:0] cnt_r;
  logic                   busy_r;
  logic                   done_r;

  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   dv;
  logic                 take;
  logic [DIV_DEN_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, low_r[DIV_LOW_W-1]};
    dv      = {1'b0, div_r};
    take    = trial >= dv;
    rem_nxt = take ? DIV_DEN_W'(trial - dv) : DIV_DEN_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_STEPS_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= DIV_DEN_W'(req.rem0);
      low_r <= req.low;
      div_r <= req.divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[DIV_LOW_W-2:0], 1'b0};
      quo_r <= {quo_r[DIV_LOW_W-2:0], take};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: src/apu_sqrt.sv
// Digit-by-digit integer square root of a 64-bit radicand, one root bit per cycle.
module apu_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  apu_pkg::sqrt_req_t req,
  output apu_pkg::sqrt_rsp_t rsp
);
  import apu_pkg::*;

  localparam int ROOT_W = 32;
  localparam int REM_W  = ROOT_W + 2;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] rad_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;

  logic [REM_W+1:0] cand;
  logic [REM_W+1:0] trial;
  logic             take;
  logic [REM_W-1:0] rem_nxt;

  always_comb begin
    cand    = {rem_r, rad_r[2*ROOT_W-1 -: 2]};
    trial   = {2'b00, root_r, 2'b01};
    take    = cand >= trial;
    rem_nxt = take ? REM_W'(cand - trial) : REM_W'(cand);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rad_r  <= req.radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[2*ROOT_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_r[ROOT_W-2:0], take};
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

FILE: src/adam_parameter_update.sv
// Top level of the element-wise Adam parameter update with moment memory.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tdata: tensor, element, param, gradient; tlast: first
//  out_    | out | out_tvalid/out_tready| tdata: new param; tuser: saturated
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  An element passes from acceptance to the output register through accept and read,
//  products, square root, divider and load; the divider is skipped when the step
//  magnitude clips. A time-step advance adds powers, schedule, root and rate division,
//  plus the warmup division during warmup; the rate division is skipped when the rate clips.
//  A result not yet taken stalls the next one at the load. After reset a clearing pass zeroes
//  the moment memory with no input taken; cfg_ready is high in idle while no input is taken.
module adam_parameter_update #(
  parameter int MAX_TENSORS         = apu_pkg::MAX_TENSORS_DEF,
  parameter int ELEMENTS_PER_TENSOR = apu_pkg::ELEMENTS_PER_TENSOR_DEF,
  parameter int DECAY_PERIOD        = apu_pkg::DECAY_PERIOD_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tensor_index[1:0], element_index[11:2], param_value[43:12], gradient[75:44]
  input  logic [apu_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // new_param_value[31:0]
  output logic [apu_pkg::OUT_TDATA_W-1:0] out_tdata,
  // saturated[0]
  output logic                            out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [apu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [apu_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import apu_pkg::*;

  localparam int DEPTH   = MAX_TENSORS * ELEMENTS_PER_TENSOR;
  localparam int AW      = $clog2(DEPTH);
  localparam int PHASE_W = $clog2(DECAY_PERIOD + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_PW, S_SCH, S_WST, S_WDW, S_C, S_SQ1, S_RDV, S_RDW,
    S_M0, S_M1, S_V0, S_V1, S_SQ2, S_DV, S_DW, S_FIN
  } state_t;

  state_t state_r;

  logic [23:0] lr_r;
  logic [15:0] b1_r;
  logic [15:0] b2_r;
  logic [31:0] eps_r;
  logic        sched_r;
  logic [19:0] wl_r;

  logic [31:0]        step_r;
  logic [PHASE_W-1:0] phase_r;
  logic [31:0]        bfp_r;
  logic [31:0]        bsp_r;
  logic [23:0]        cur_r;
  logic [31:0]        eff_r;

  logic               clearing_r;
  logic [AW-1:0]      clr_cnt_r;

  logic [AW-1:0]      addr_r;
  logic               first_r;
  logic signed [31:0] p_r;
  logic signed [31:0] g_r;
  logic [63:0]        mem_rd_r;
  logic [63:0]        mem [DEPTH];

  logic [63:0]        num_r;
  logic [32:0]        c1_r;
  logic signed [49:0] pm1_r;
  logic signed [49:0] pm2_r;
  logic [31:0]        mag_r;
  logic signed [31:0] m_r;
  logic [39:0]        gsq_r;
  logic [47:0]        pv1_r;
  logic [56:0]        pv2_r;
  logic [36:0]        den_r;
  logic [48:0]        delta_r;

  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_sat_r;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  logic [31:0]        t_mod;
  logic [31:0]        e_mod;
  logic [AW-1:0]      addr_in;
  logic               step_in;
  logic               in_acc;
  logic               out_free;

  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [63:0]        mem_wd;

  logic signed [31:0] m_old;
  logic [31:0]        v_old;
  logic signed [50:0] m_sum;
  logic signed [34:0] m_sh;
  logic signed [31:0] m_new;
  logic [57:0]        v_sum;
  logic [41:0]        v_sh;
  logic [31:0]        v_new;
  logic [31:0]        c2;
  logic [31:0]        m_abs;
  logic [36:0]        den_nxt;
  logic               rate_sat;
  logic               elem_sat;
  logic signed [50:0] np;
  logic [31:0]        np_sat;
  logic               np_clip;
  logic [31:0]        step_nxt;

  apu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  apu_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  always_comb begin
    t_mod    = 32'(in_tdata[1:0]) % MAX_TENSORS;
    e_mod    = 32'(in_tdata[11:2]) % ELEMENTS_PER_TENSOR;
    addr_in  = AW'(t_mod * ELEMENTS_PER_TENSOR + e_mod);
    step_in  = in_tlast && (t_mod == 32'd0);
    in_acc   = in_tvalid && in_tready;
    out_free = !out_valid_r || out_tready;
    step_nxt = step_r + 32'd1;

    m_old = $signed(mem_rd_r[31:0]);
    v_old = mem_rd_r[63:32];

    m_sum = 51'(pm1_r) + 51'(pm2_r) + 51'sd32768;
    m_sh  = 35'(m_sum >>> 16);
    if (m_sh > 35'sd2147483647) begin
      m_new = 32'sh7FFF_FFFF;
    end else if (m_sh < -35'sd2147483648) begin
      m_new = 32'sh8000_0000;
    end else begin
      m_new = 32'(m_sh);
    end

    v_sum = 58'(pv1_r) + 58'(pv2_r) + 58'd32768;
    v_sh  = v_sum[57:16];
    v_new = (|v_sh[41:32]) ? 32'hFFFF_FFFF : v_sh[31:0];

    c2       = (bsp_r == 32'd0) ? 32'hFFFF_FFFF : (~bsp_r + 32'd1);
    m_abs    = m_r[31] ? (~32'(m_r) + 32'd1) : 32'(m_r);
    den_nxt  = {sqrt_rsp.root[28:0], 8'd0} + 37'(eps_r);
    rate_sat = 33'(num_r[55:32]) >= c1_r;
    elem_sat = 37'(num_r[63:40]) >= den_r;

    if (m_r[31]) begin
      np = 51'(p_r) + $signed({2'b00, delta_r});
    end else begin
      np = 51'(p_r) - $signed({2'b00, delta_r});
    end
    if (np > 51'sd2147483647) begin
      np_sat  = 32'h7FFF_FFFF;
      np_clip = 1'b1;
    end else if (np < -51'sd2147483648) begin
      np_sat  = 32'h8000_0000;
      np_clip = 1'b1;
    end else begin
      np_sat  = 32'(np);
      np_clip = 1'b0;
    end
  end

  always_comb begin
    div_req  = '0;
    sqrt_req = '0;
    unique case (state_r)
      S_WST: begin
        div_req.start   = 1'b1;
        div_req.steps   = DIV_STEPS_W'(24);
        div_req.rem0    = num_r[47:24];
        div_req.low     = {num_r[23:0], 24'd0};
        div_req.divisor = 37'(wl_r);
      end
      S_RDV: begin
        div_req.start   = !rate_sat;
        div_req.steps   = DIV_STEPS_W'(32);
        div_req.rem0    = num_r[55:32];
        div_req.low     = {num_r[31:0], 16'd0};
        div_req.divisor = 37'(c1_r);
      end
      S_DV: begin
        div_req.start   = !elem_sat;
        div_req.steps   = DIV_STEPS_W'(48);
        div_req.rem0    = num_r[63:40];
        div_req.low     = {num_r[39:0], 8'd0};
        div_req.divisor = den_r;
      end
      S_C: begin
        sqrt_req.start    = 1'b1;
        sqrt_req.radicand = {c2, 32'd0};
      end
      S_V1: begin
        sqrt_req.start    = 1'b1;
        sqrt_req.radicand = {8'd0, v_new, 24'd0};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mem_we = clearing_r || (state_r == S_V1);
    mem_wa = clearing_r ? clr_cnt_r : addr_r;
    mem_wd = clearing_r ? 64'd0 : {v_new, m_r};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lr_r        <= LEARNING_RATE_RST;
      b1_r        <= BETA_FIRST_RST;
      b2_r        <= BETA_SECOND_RST;
      eps_r       <= EPSILON_RST;
      sched_r     <= 1'b0;
      wl_r        <= '0;
      step_r      <= '0;
      phase_r     <= '0;
      bfp_r       <= POWER_ONE;
      bsp_r       <= POWER_ONE;
      cur_r       <= LEARNING_RATE_RST;
      eff_r       <= '0;
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          clearing_r <= 1'b0;
        end
      end

      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            addr_r  <= addr_in;
            first_r <= step_in;
            p_r     <= $signed(in_tdata[43:12]);
            g_r     <= $signed(in_tdata[75:44]);
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= first_r ? S_PW : S_M0;
        end
        S_PW: begin
          bfp_r  <= 32'((48'(bfp_r) * 48'(b1_r)) >> 16);
          bsp_r  <= 32'((48'(bsp_r) * 48'(b2_r)) >> 16);
          step_r <= step_nxt;
          if (step_nxt == 32'd0 || phase_r == PHASE_W'(DECAY_PERIOD - 1)) begin
            phase_r <= '0;
          end else begin
            phase_r <= phase_r + 1'b1;
          end
          state_r <= S_SCH;
        end
        S_SCH: begin
          num_r <= 64'(56'(lr_r) * 56'(step_r));
          if (sched_r && (step_r < 32'(wl_r))) begin
            state_r <= S_WST;
          end else begin
            if (sched_r && phase_r == '0) begin
              cur_r <= cur_r >> 1;
            end
            state_r <= S_C;
          end
        end
        S_WST: begin
          state_r <= S_WDW;
        end
        S_WDW: begin
          if (div_rsp.done) begin
            cur_r   <= div_rsp.quotient[23:0];
            state_r <= S_C;
          end
        end
        S_C: begin
          c1_r    <= 33'h1_0000_0000 - 33'(bfp_r);
          state_r <= S_SQ1;
        end
        S_SQ1: begin
          if (sqrt_rsp.done) begin
            num_r   <= 64'(56'(cur_r) * 56'(sqrt_rsp.root));
            state_r <= S_RDV;
          end
        end
        S_RDV: begin
          if (rate_sat) begin
            eff_r   <= 32'hFFFF_FFFF;
            state_r <= S_M0;
          end else begin
            state_r <= S_RDW;
          end
        end
        S_RDW: begin
          if (div_rsp.done) begin
            eff_r   <= div_rsp.quotient[31:0];
            state_r <= S_M0;
          end
        end
        S_M0: begin
          pm1_r   <= 50'($signed({1'b0, b1_r})) * 50'(m_old);
          pm2_r   <= 50'($signed(18'sd65536 - $signed({2'b00, b1_r}))) * 50'(g_r);
          mag_r   <= g_r[31] ? (~32'(g_r) + 32'd1) : 32'(g_r);
          state_r <= S_M1;
        end
        S_M1: begin
          m_r     <= m_new;
          gsq_r   <= 40'((64'(mag_r) * 64'(mag_r)) >> 24);
          state_r <= S_V0;
        end
        S_V0: begin
          pv1_r   <= 48'(b2_r) * 48'(v_old);
          pv2_r   <= 57'(17'h1_0000 - 17'(b2_r)) * 57'(gsq_r);
          state_r <= S_V1;
        end
        S_V1: begin
          state_r <= S_SQ2;
        end
        S_SQ2: begin
          if (sqrt_rsp.done) begin
            den_r   <= (den_nxt == 37'd0) ? 37'd1 : den_nxt;
            num_r   <= 64'(eff_r) * 64'(m_abs);
            state_r <= S_DV;
          end
        end
        S_DV: begin
          if (elem_sat) begin
            delta_r <= 49'h1_0000_0000_0000;
            state_r <= S_FIN;
          end else begin
            state_r <= S_DW;
          end
        end
        S_DW: begin
          if (div_rsp.done) begin
            delta_r <= {1'b0, div_rsp.quotient};
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_data_r  <= np_sat;
            out_sat_r   <= np_clip;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_LEARNING_RATE: begin
            lr_r  <= cfg_data[23:0];
            cur_r <= cfg_data[23:0];
          end
          CFG_BETA_FIRST:      b1_r    <= cfg_data[15:0];
          CFG_BETA_SECOND:     b2_r    <= cfg_data[15:0];
          CFG_EPSILON_VALUE:   eps_r   <= cfg_data;
          CFG_SCHEDULE_ENABLE: sched_r <= cfg_data[0];
          CFG_WARMUP_LENGTH:   wl_r    <= cfg_data[19:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE) && !clearing_r;
  assign cfg_ready  = (state_r == S_IDLE) && !in_acc;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_tready)
    else $error("input taken during memory clearing pass");

  a_write_only_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && !clearing_r) |-> (state_r == S_V1))
    else $error("moment memory written outside the update state");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished result not moved to output register");

  a_no_unit_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !sqrt_req.start)
    else $error("divider and root unit started together");

endmodule

FILE: dv/adam_parameter_update_test.sv
// Self-checking regression of the Adam update block under directed and random stream traffic.
`timescale 1ns / 1ps

class adam_scoreboard;
  typedef struct {
    logic [31:0] value;
    logic        sat;
  } update_t;

  update_t     expected_updates[$];
  logic [23:0] base_rate;
  logic [15:0] decay_first;
  logic [15:0] decay_second;
  logic [31:0] guard;
  logic        sched_on;
  logic [19:0] ramp_steps;
  logic [31:0] moment_one [4096];
  logic [31:0] moment_two [4096];
  logic [31:0] steps;
  logic [31:0] power_first;
  logic [31:0] power_second;
  logic [23:0] rate_now;
  logic [31:0] rate_eff;
  int          mismatches;
  int          checked;
  int          step_advances;
  int          sat_seen;

  function new();
    base_rate = apu_pkg::LEARNING_RATE_RST;
    decay_first = apu_pkg::BETA_FIRST_RST;
    decay_second = apu_pkg::BETA_SECOND_RST;
    guard = apu_pkg::EPSILON_RST;
    sched_on = 1'b0;
    ramp_steps = '0;
    foreach (moment_one[i]) begin
      moment_one[i] = '0;
      moment_two[i] = '0;
    end
    steps = '0;
    power_first = apu_pkg::POWER_ONE;
    power_second = apu_pkg::POWER_ONE;
    rate_now = base_rate;
    rate_eff = '0;
  endfunction

  function logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      apu_pkg::CFG_LEARNING_RATE: begin
        base_rate = data[23:0];
        rate_now = data[23:0];
      end
      apu_pkg::CFG_BETA_FIRST: decay_first = data[15:0];
      apu_pkg::CFG_BETA_SECOND: decay_second = data[15:0];
      apu_pkg::CFG_EPSILON_VALUE: guard = data;
      apu_pkg::CFG_SCHEDULE_ENABLE: sched_on = data[0];
      apu_pkg::CFG_WARMUP_LENGTH: ramp_steps = data[19:0];
      default: ;
    endcase
  endfunction

  function void advance_time_step();
    logic [63:0] c1, c2, num, q;
    steps++;
    step_advances++;
    power_first = 32'((64'(power_first) * decay_first) >> 16);
    power_second = 32'((64'(power_second) * decay_second) >> 16);
    if (sched_on) begin
      if (steps < 32'(ramp_steps))
        rate_now = 24'((64'(base_rate) * steps) / ramp_steps);
      else if (steps % apu_pkg::DECAY_PERIOD_DEF == 0)
        rate_now = rate_now >> 1;
    end
    c1 = (64'd1 << 32) - power_first;
    c2 = (64'd1 << 32) - power_second;
    if (c2 > 64'hFFFF_FFFF) c2 = 64'hFFFF_FFFF;
    num = 64'(rate_now) * int_sqrt(c2 << 32);
    q = num / c1;
    rate_eff = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function void note_input(logic [1:0] t, logic [9:0] e, logic first,
                           logic [31:0] p, logic [31:0] g);
    int          addr;
    longint      acc, m, np, delta, gs, ps;
    logic [63:0] mag, gsq, v, den, num, q, rem, mm;
    update_t     u;
    addr = int'(t) * 1024 + int'(e);
    gs = longint'($signed(g));
    ps = longint'($signed(p));
    if (first && t == 0) advance_time_step();
    acc = longint'(decay_first) * longint'($signed(moment_one[addr]))
          + longint'(65536 - int'(decay_first)) * gs + 32768;
    m = acc >>> 16;
    if (m > 64'sd2147483647) m = 64'sd2147483647;
    if (m < -64'sd2147483648) m = -64'sd2147483648;
    moment_one[addr] = m[31:0];
    mag = (gs < 0) ? 64'(-gs) : 64'(gs);
    gsq = (mag * mag) >> 24;
    v = (64'(decay_second) * moment_two[addr] + 64'(65536 - int'(decay_second)) * gsq
         + 64'd32768) >> 16;
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    moment_two[addr] = v[31:0];
    den = (int_sqrt(v << 24) << 8) + guard;
    if (den == 0) den = 1;
    mm = (m < 0) ? 64'(-m) : 64'(m);
    num = 64'(rate_eff) * mm;
    q = num / den;
    rem = num % den;
    if (q >= (64'd1 << 40)) delta = longint'(1) << 48;
    else delta = longint'((q << 8) + (rem << 8) / den);
    if (m < 0) delta = -delta;
    np = ps - delta;
    u.sat = 1'b0;
    if (np > 64'sd2147483647) begin
      np = 64'sd2147483647;
      u.sat = 1'b1;
    end
    if (np < -64'sd2147483648) begin
      np = -64'sd2147483648;
      u.sat = 1'b1;
    end
    u.value = np[31:0];
    expected_updates.push_back(u);
  endfunction

  function void check_result(logic [31:0] value, logic sat);
    update_t u;
    if (expected_updates.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h sat %b", value, sat);
      return;
    end
    u = expected_updates.pop_front();
    checked++;
    if (u.sat) sat_seen++;
    if (value !== u.value || sat !== u.sat) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch #%0d: expected %h sat %b, got %h sat %b",
                 checked, u.value, u.sat, value, sat);
    end
  endfunction
endclass

module adam_parameter_update_test;
  import apu_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 3'd6;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  adam_scoreboard sb;
  int             burst_left;
  int             stall_mode;
  int             stall_left;
  int             phase_count;

  adam_parameter_update uut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("adam_parameter_update regression: fail");
    $finish;
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(50, 400);
    end
    stall_left--;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 1) != 0);
      default: out_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  task automatic push_element(logic [1:0] t, logic [9:0] e, logic first,
                              logic [31:0] p, logic [31:0] g);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {4'b0, g, p, e, t};
    in_tlast = first;
    do @(posedge clk); while (!in_tready);
    sb.note_input(t, e, first, p, g);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.expected_updates.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_all(logic [23:0] lr, logic [15:0] b1, logic [15:0] b2,
                         logic [31:0] eps, logic sch, logic [19:0] warm);
    drain();
    write_cfg(CFG_LEARNING_RATE, {8'b0, lr});
    write_cfg(CFG_BETA_FIRST, {16'b0, b1});
    write_cfg(CFG_BETA_SECOND, {16'b0, b2});
    write_cfg(CFG_EPSILON_VALUE, eps);
    write_cfg(CFG_SCHEDULE_ENABLE, {31'b0, sch});
    write_cfg(CFG_WARMUP_LENGTH, {12'b0, warm});
    phase_count++;
  endtask

  function automatic logic [31:0] rand_grad();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
      2: return 32'($signed($urandom_range(0, 32'h0001_FFFF)) - 32'sh0001_0000);
      default: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom)};
    endcase
  endfunction

  task automatic random_traffic(int count);
    logic [1:0] t;
    int         e;
    int         n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 8) begin
        t = 2'($urandom_range(0, 3));
        e = $urandom_range(0, 1023 - 16);
        for (int k = 0; k < 16 && n < count; k++) begin
          push_element(t, 10'(e + k), k == 0, $urandom, rand_grad());
          n++;
        end
      end else begin
        push_element(2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)),
                     1'($urandom_range(0, 1)), $urandom, rand_grad());
        n++;
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    burst_left = 0;
    phase_count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    push_element(2'd1, 10'd5, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
    push_element(2'd3, 10'd1023, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
    push_element(2'd0, 10'd0, 1'b1, 32'h0100_0000, 32'h0100_0000);
    push_element(2'd0, 10'd1, 1'b0, 32'h0, 32'h0);
    push_element(2'd0, 10'd1023, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_element(2'd2, 10'd512, 1'b1, 32'h1234_5678, 32'h0000_0001);
    push_element(2'd0, 10'd0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
    set_all(24'hFF_FFFF, 16'd1, 16'd1, 32'd1, 1'b0, 20'd0);
    write_cfg(CFG_UNMAPPED, 32'hFFFF_FFFF);
    push_element(2'd0, 10'd7, 1'b1, 32'h7FFF_FFF0, 32'h8000_0000);
    push_element(2'd0, 10'd8, 1'b0, 32'h8000_0010, 32'h7FFF_FFFF);
    push_element(2'd3, 10'd9, 1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push_element(2'd1, 10'd10, 1'b0, 32'h0, 32'h0000_0001);
    set_all(24'd1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 20'd3);
    for (int k = 0; k < 6; k++) push_element(2'd0, 10'(k), 1'b1, $urandom, rand_grad());

    random_traffic(350);
    set_all(24'd16777, 16'd58982, 16'd65470, 32'd43, 1'b1, 20'hF_FFFF);
    random_traffic(350);
    drain();
    random_traffic(100);
    set_all(24'h80_0000, 16'd32768, 16'd1, 32'd0 + 32'd1, 1'b1, 20'd0);
    random_traffic(350);
    set_all(24'h00_1000, 16'hFFFF, 16'h8000, 32'hFFFF_FFFF, 1'b0, 20'd50);
    random_traffic(300);
    set_all(24'h3F_FFFF, 16'd60000, 16'd65000, 32'd1000, 1'b1, 20'd40);
    random_traffic(350);

    drain();
    $display("ran %0d updates across %0d register settings, %0d time steps, %0d clipped",
             sb.checked, phase_count, sb.step_advances, sb.sat_seen);
    if (sb.mismatches == 0 && sb.expected_updates.size() == 0) begin
      $display("adam_parameter_update regression: pass");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("adam_parameter_update regression: fail");
    end
    $finish;
  end
endmodule

FILE: sim.f
src/apu_pkg.sv
src/apu_div.sv
src/apu_sqrt.sv
src/adam_parameter_update.sv
dv/adam_parameter_update_test.sv
